/* hw/rtl/rhc_pkg.sv */
// ----------------------------------------------------------------------------
// rhc_pkg
// shared types and constants of the rgb / hsv / hsl color converter
// ----------------------------------------------------------------------------
package rhc_pkg;

   localparam int CH_W        = 8;      // one color channel
   localparam int NUM_W       = 24;     // widest numerator, 255^3 fits
   localparam int DEN_W       = 16;     // widest denominator, 255^2 fits
   localparam int CHANNELS    = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DEN_W-1:0] DEN_SQ = 16'd65025;  // 255 * 255

   typedef enum logic [1:0] {
      MODE_RGB_HSL = 2'd0,
      MODE_HSL_RGB = 2'd1,
      MODE_RGB_HSV = 2'd2,
      MODE_HSV_RGB = 2'd3
   } mode_type;

   typedef logic [CH_W-1:0]  chan_type;
   typedef logic [NUM_W-1:0] num_type;
   typedef logic [DEN_W-1:0] den_type;

   // one pixel worth of division jobs, index 0 is channel a
   typedef struct packed {
      num_type [CHANNELS-1:0] num;
      den_type [CHANNELS-1:0] den;
   } job_type;

endpackage

/* hw/rtl/rhc_front.sv */
// ----------------------------------------------------------------------------
// rhc_front
// two stage front end: classifies a pixel and forms numerator / denominator
// ----------------------------------------------------------------------------
module rhc_front (
   input  logic              clock,
   input  logic              reset,
   input  rhc_pkg::mode_type mode,
   input  logic              req_valid,
   output logic              req_ready,
   input  rhc_pkg::chan_type req_chan_a,
   input  rhc_pkg::chan_type req_chan_b,
   input  rhc_pkg::chan_type req_chan_c,
   output logic              job_valid,
   input  logic              job_ready,
   output rhc_pkg::job_type  job
);
   import rhc_pkg::*;

   // stage 1 registers
   logic     vld1_ff, vld1_in;
   mode_type mode1_ff;
   chan_type mx_ff, d_ff, l_ff;
   logic [8:0]  sum_ff;
   logic [10:0] hn_ff;
   logic        grey_ff;
   logic [15:0] q_ff, p_ff;
   chan_type    t_ff [CHANNELS];
   logic        szero_ff;
   logic [15:0] vs_ff, vns_ff;
   logic [2:0]  k_ff;
   chan_type    cd_ff;

   logic [8:0]  sum_in;
   logic [10:0] hn_in;
   chan_type    mx_in, d_in;
   logic [15:0] q_in, p_in, vs_in, vns_in;
   chan_type    t_in [CHANNELS];
   logic [2:0]  k_in;
   chan_type    cd_in;

   // stage 2 registers
   logic    vld2_ff, vld2_in;
   job_type job_ff, job_in;

   logic adv;

   assign adv       = !vld2_ff || job_ready;
   assign req_ready = adv;
   assign vld1_in   = adv ? req_valid : vld1_ff;
   assign vld2_in   = adv ? vld1_ff : vld2_ff;
   assign job_valid = vld2_ff;
   assign job       = job_ff;

   // ---- stage 1 combinational ----
   chan_type    r, g, b, mn;
   logic [15:0] ls, l255;
   logic [16:0] q17, p17;
   logic [8:0]  ta9;
   logic [10:0] h6, u;

   always_comb begin
      r  = req_chan_a;
      g  = req_chan_b;
      b  = req_chan_c;
      mx_in = r;
      mn = r;
      if (g > mx_in) mx_in = g;
      if (b > mx_in) mx_in = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d_in   = mx_in - mn;
      sum_in = {1'b0, mx_in} + {1'b0, mn};
      if (r == mx_in) begin
         if (g < b) hn_in = ({3'b0, d_in} * 11'd6) + {3'b0, g} - {3'b0, b};
         else       hn_in = {3'b0, g} - {3'b0, b};
      end else if (g == mx_in) begin
         hn_in = {2'b0, d_in, 1'b0} + {3'b0, b} - {3'b0, r};
      end else begin
         hn_in = {1'b0, d_in, 2'b0} + {3'b0, r} - {3'b0, g};
      end

      // hsl: h = a, s = b, l = c
      ls   = req_chan_c * req_chan_b;
      l255 = {req_chan_c, 8'b0} - {8'b0, req_chan_c};
      if ({req_chan_c, 1'b0} < 9'd255)
         q17 = {1'b0, l255} + {1'b0, ls};
      else
         q17 = {1'b0, l255} + {1'b0, {req_chan_b, 8'b0} - {8'b0, req_chan_b}} - {1'b0, ls};
      p17  = {l255, 1'b0} - q17;
      q_in = q17[15:0];
      p_in = p17[15:0];
      ta9  = {1'b0, req_chan_a} + 9'd85;
      t_in[0] = (ta9 > 9'd255) ? 8'(ta9 - 9'd255) : ta9[7:0];
      t_in[1] = req_chan_a;
      t_in[2] = (req_chan_a < 8'd85) ? req_chan_a + 8'd170 : req_chan_a - 8'd85;

      // hsv: sector and distance from sector center
      h6 = {req_chan_a, 2'b0} + {2'b0, req_chan_a, 1'b0};
      if (h6 < 11'd255)       begin k_in = 3'd0; u = h6;            end
      else if (h6 < 11'd510)  begin k_in = 3'd1; u = h6;            end
      else if (h6 < 11'd765)  begin k_in = 3'd2; u = h6 - 11'd510;  end
      else if (h6 < 11'd1020) begin k_in = 3'd3; u = h6 - 11'd510;  end
      else if (h6 < 11'd1275) begin k_in = 3'd4; u = h6 - 11'd1020; end
      else if (h6 < 11'd1530) begin k_in = 3'd5; u = h6 - 11'd1020; end
      else                    begin k_in = 3'd0; u = 11'd0;         end
      cd_in  = (u >= 11'd255) ? 8'(11'd510 - u) : 8'(u);  // 255 - |u - 255|
      vs_in  = req_chan_c * req_chan_b;
      vns_in = req_chan_c * (8'd255 - req_chan_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= vld1_in;
         vld2_ff <= vld2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode1_ff <= mode;
         mx_ff    <= mx_in;
         d_ff     <= d_in;
         sum_ff   <= sum_in;
         hn_ff    <= hn_in;
         grey_ff  <= (d_in == 8'd0);
         l_ff     <= req_chan_c;
         q_ff     <= q_in;
         p_ff     <= p_in;
         t_ff     <= t_in;
         szero_ff <= (req_chan_b == 8'd0);
         vs_ff    <= vs_in;
         vns_ff   <= vns_in;
         k_ff     <= k_in;
         cd_ff    <= cd_in;
         job_ff   <= job_in;
      end
   end

   // ---- stage 2 combinational ----
   function automatic num_type hsl_chan(input logic [15:0] p, input logic [15:0] q,
                                        input chan_type t);
      num_type     p255, prod;
      logic [15:0] diff;
      chan_type    w6;
      p255 = {p, 8'b0} - {8'b0, p};
      diff = q - p;
      w6   = 8'd0;
      if (t <= 8'd42)       w6 = 8'(t * 3'd6);
      else if (t >= 8'd128 && t < 8'd170) w6 = 8'((8'd170 - t) * 3'd6);
      prod = diff * w6;
      if (t > 8'd42 && t <= 8'd127) hsl_chan = {q, 8'b0} - {8'b0, q};
      else                          hsl_chan = p255 + prod;
   endfunction

   num_type c255, x, m;
   num_type chn [CHANNELS];

   always_comb begin
      c255 = {vs_ff, 8'b0} - {8'b0, vs_ff};
      x    = vs_ff * cd_ff;
      m    = {vns_ff, 8'b0} - {8'b0, vns_ff};
      case (k_ff)
         3'd0:    begin chn[0] = c255; chn[1] = x;    chn[2] = '0;   end
         3'd1:    begin chn[0] = x;    chn[1] = c255; chn[2] = '0;   end
         3'd2:    begin chn[0] = '0;   chn[1] = c255; chn[2] = x;    end
         3'd3:    begin chn[0] = '0;   chn[1] = x;    chn[2] = c255; end
         3'd4:    begin chn[0] = x;    chn[1] = '0;   chn[2] = c255; end
         default: begin chn[0] = c255; chn[1] = '0;   chn[2] = x;    end
      endcase

      job_in = '0;
      case (mode1_ff)
         MODE_RGB_HSL, MODE_RGB_HSV: begin
            if (grey_ff) begin
               job_in.den[0] = 16'd1;
               job_in.den[1] = 16'd1;
            end else begin
               job_in.num[0] = NUM_W'({hn_ff, 8'b0} - {8'b0, hn_ff});
               job_in.den[0] = DEN_W'({d_ff, 2'b0} + {d_ff, 1'b0});
               job_in.num[1] = NUM_W'({d_ff, 8'b0} - {8'b0, d_ff});
               if (mode1_ff == MODE_RGB_HSV)
                  job_in.den[1] = DEN_W'(mx_ff);
               else if (sum_ff > 9'd255)
                  job_in.den[1] = DEN_W'(10'd510 - {1'b0, sum_ff});
               else
                  job_in.den[1] = DEN_W'(sum_ff);
            end
            if (mode1_ff == MODE_RGB_HSV) begin
               job_in.num[2] = NUM_W'(mx_ff);
               job_in.den[2] = 16'd1;
            end else begin
               job_in.num[2] = NUM_W'(sum_ff);
               job_in.den[2] = 16'd2;
            end
         end
         MODE_HSL_RGB: begin
            for (int i = 0; i < CHANNELS; i++) begin
               if (szero_ff) begin
                  job_in.num[i] = NUM_W'(l_ff);
                  job_in.den[i] = 16'd1;
               end else begin
                  job_in.num[i] = hsl_chan(p_ff, q_ff, t_ff[i]);
                  job_in.den[i] = DEN_SQ;
               end
            end
         end
         default: begin
            for (int i = 0; i < CHANNELS; i++) begin
               job_in.num[i] = chn[i] + m;
               job_in.den[i] = DEN_SQ;
            end
         end
      endcase
   end

endmodule

/* hw/rtl/rhc_queue.sv */
// ----------------------------------------------------------------------------
// rhc_queue
// short fifo of division jobs between front end and divider
// ----------------------------------------------------------------------------
module rhc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rhc_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output rhc_pkg::job_type pop_job
);
   import rhc_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]      cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = (cnt_ff != (PW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_job    = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign wr_in      = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in      = pop ? rd_ff + 1'b1 : rd_ff;
   assign cnt_in     = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_job;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PW+1)'(QUEUE_DEPTH)) else $error("queue overfilled");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      PW'(wr_ff - rd_ff) == cnt_ff[PW-1:0]) else $error("queue pointers disagree with count");

endmodule

/* hw/rtl/rhc_divider.sv */
// ----------------------------------------------------------------------------
// rhc_divider
// pipelined restoring divider, one quotient bit per stage, then rounding
// ----------------------------------------------------------------------------
module rhc_divider #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  rhc_pkg::job_type  job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rhc_pkg::chan_type rsp_out_a,
   output rhc_pkg::chan_type rsp_out_b,
   output rhc_pkg::chan_type rsp_out_c
);
   import rhc_pkg::*;

   localparam int QW = CH_W + FRAC_BITS;   // quotient bits

   logic            vld_ff [QW+1];
   den_type         rem_ff [QW+1][CHANNELS];
   den_type         den_ff [QW+1][CHANNELS];
   logic [QW-1:0]   qr_ff  [QW+1][CHANNELS];
   logic            out_vld_ff, out_vld_in;
   chan_type        out_ff [CHANNELS];
   chan_type        out_in [CHANNELS];
   logic            adv;

   assign adv        = !out_vld_ff || rsp_ready;
   assign job_ready  = adv;
   assign out_vld_in = adv ? vld_ff[QW] : out_vld_ff;
   assign rsp_valid  = out_vld_ff;
   assign rsp_out_a  = out_ff[0];
   assign rsp_out_b  = out_ff[1];
   assign rsp_out_c  = out_ff[2];

   // stage 0: top of dividend is the first partial remainder
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int c = 0; c < CHANNELS; c++) begin
            rem_ff[0][c] <= DEN_W'(job.num[c][NUM_W-1:CH_W]);
            den_ff[0][c] <= job.den[c];
            qr_ff[0][c]  <= {job.num[c][CH_W-1:0], {FRAC_BITS{1'b0}}};
         end
      end
   end

   for (genvar j = 1; j <= QW; j++) begin : g_stage
      logic [DEN_W:0] trial [CHANNELS];
      logic           ge    [CHANNELS];
      den_type        rem_in [CHANNELS];
      logic [QW-1:0]  qr_in  [CHANNELS];
      always_comb begin
         for (int c = 0; c < CHANNELS; c++) begin
            trial[c]  = {rem_ff[j-1][c], qr_ff[j-1][c][QW-1]};
            ge[c]     = (trial[c] >= {1'b0, den_ff[j-1][c]});
            rem_in[c] = ge[c] ? DEN_W'(trial[c] - {1'b0, den_ff[j-1][c]})
                              : trial[c][DEN_W-1:0];
            qr_in[c]  = {qr_ff[j-1][c][QW-2:0], ge[c]};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_ff[j-1];
            qr_ff[j]  <= qr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QW; j++) vld_ff[j] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= job_valid;
         for (int j = 1; j <= QW; j++) vld_ff[j] <= vld_ff[j-1];
      end
   end

   // round half up, saturate
   logic [QW:0] rnd [CHANNELS];
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         rnd[c]    = {1'b0, qr_ff[QW][c]} + ((QW+1)'(1) << (FRAC_BITS - 1));
         out_in[c] = rnd[c][QW] ? 8'd255 : rnd[c][QW-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else       out_vld_ff <= out_vld_in;
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   a_rem_start: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> (rem_ff[0][0] < den_ff[0][0] && rem_ff[0][1] < den_ff[0][1]
                     && rem_ff[0][2] < den_ff[0][2]))
      else $error("quotient would overflow");
   a_rem_end: assert property (@(posedge clock) disable iff (reset)
      vld_ff[QW] |-> (rem_ff[QW][0] < den_ff[QW][0]))
      else $error("remainder not reduced");

endmodule

/* hw/rtl/rgb_hsv_hsl_converter.sv */
// ----------------------------------------------------------------------------
// rgb_hsv_hsl_converter
// per pixel conversion between rgb and hsl / hsv
// ----------------------------------------------------------------------------
// One pixel request per clock is taken and one result per clock is returned,
// in order, while the result side does not stall. Two front-end stages form
// each channel as an exact fraction, a four-entry queue follows, and a
// pipelined restoring divider spends one stage per quotient bit
// (8 + FRAC_BITS stages) ahead of the rounding register. The front end and
// the divider stall on their own; the queue absorbs the difference. The user
// must write the mode register (0 rgb to hsl, 1 hsl to rgb, 2 rgb to hsv,
// 3 hsv to rgb) only while idle; the block itself does not enforce it.
// Hue is coded 0..255 over the full circle.
// ----------------------------------------------------------------------------
module rgb_hsv_hsl_converter #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  rhc_pkg::chan_type req_chan_a,
   input  rhc_pkg::chan_type req_chan_b,
   input  rhc_pkg::chan_type req_chan_c,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rhc_pkg::chan_type rsp_out_a,
   output rhc_pkg::chan_type rsp_out_b,
   output rhc_pkg::chan_type rsp_out_c
);
   import rhc_pkg::*;

   // mode register, always writable
   mode_type mode_ff, mode_in;
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? mode_type'(csr_data) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_RGB_HSL;
      else       mode_ff <= mode_in;
   end

   // front end to queue
   logic    fj_valid, fj_ready;
   job_type fj;
   // queue to divider
   logic    dj_valid, dj_ready;
   job_type dj;

   // classify and build numerator / denominator
   rhc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_chan_a (req_chan_a),
      .req_chan_b (req_chan_b),
      .req_chan_c (req_chan_c),
      .job_valid  (fj_valid),
      .job_ready  (fj_ready),
      .job        (fj)
   );

   // decouples the two halves
   rhc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fj_valid),
      .push_ready (fj_ready),
      .push_job   (fj),
      .pop_valid  (dj_valid),
      .pop_ready  (dj_ready),
      .pop_job    (dj)
   );

   // divide, round and hold the result
   rhc_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .job_valid (dj_valid),
      .job_ready (dj_ready),
      .job       (dj),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_out_a (rsp_out_a),
      .rsp_out_b (rsp_out_b),
      .rsp_out_c (rsp_out_c)
   );

endmodule

/* verif/tb_rgb_hsv_hsl_converter.sv */
// ----------------------------------------------------------------------------
// tb_rgb_hsv_hsl_converter
// self-checking bench of the rgb / hsv / hsl color converter
// ----------------------------------------------------------------------------
// Pixels are driven through the request channel under all four modes. Each
// accepted pixel is converted by a local exact-fraction model and queued; each
// result is compared with the oldest queued pixel. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_rgb_hsv_hsl_converter;
   timeunit 1ns;
   timeprecision 1ps;
   import rhc_pkg::*;

   localparam int FRAC      = 16;
   localparam int N_RANDOM  = 1800;
   localparam int DOG_LIMIT = 2000;

   typedef struct {
      chan_type a;
      chan_type b;
      chan_type c;
   } pixel_type;

   // exact-fraction color model with a queue of expected pixels
   class pixel_scoreboard;
      mode_type  mode;
      pixel_type pending[$];
      int        errors;
      int        checked;

      function new();
         mode = MODE_RGB_HSL;
      endfunction

      function automatic longint to_byte(longint num, longint den);
         longint fx;
         longint r;
         if (den == 0) return 0;
         fx = (num << FRAC) / den;
         r = (fx + (longint'(1) << (FRAC - 1))) >> FRAC;
         return r > 255 ? 255 : r;
      endfunction

      function automatic longint hsl_chan(longint p, longint q, longint t);
         longint n;
         if (t < 0) t += 255;
         if (t > 255) t -= 255;
         if (2 * t < 85)       n = 255 * p + (q - p) * 6 * t;
         else if (2 * t < 255) n = 255 * q;
         else if (t < 170)     n = 255 * p + (q - p) * 6 * (170 - t);
         else                  n = 255 * p;
         if (n < 0) n = 0;
         return to_byte(n, 65025);
      endfunction

      function automatic pixel_type convert(pixel_type px);
         longint a, b, c, mx, mn, d, sum, hn, q, p, k, u, hue_dev, cc, x, m;
         longint o[3];
         longint ch[3];
         pixel_type res;
         a = px.a; b = px.b; c = px.c;
         case (mode)
            MODE_RGB_HSL, MODE_RGB_HSV: begin
               mx = a; mn = a;
               if (b > mx) mx = b;
               if (c > mx) mx = c;
               if (b < mn) mn = b;
               if (c < mn) mn = c;
               d = mx - mn;
               sum = mx + mn;
               o[2] = (mode == MODE_RGB_HSL) ? to_byte(sum, 2) : mx;
               if (d == 0) begin
                  o[0] = 0; o[1] = 0;
               end else begin
                  if (a == mx)      hn = (b < c) ? 6 * d + b - c : b - c;
                  else if (b == mx) hn = 2 * d + c - a;
                  else              hn = 4 * d + a - b;
                  o[0] = to_byte(255 * hn, 6 * d);
                  if (mode == MODE_RGB_HSL)
                     o[1] = to_byte(255 * d, sum > 255 ? 510 - sum : sum);
                  else
                     o[1] = to_byte(255 * d, mx);
               end
            end
            MODE_HSL_RGB: begin
               if (b == 0) begin
                  o[0] = c; o[1] = c; o[2] = c;
               end else begin
                  q = (2 * c < 255) ? c * (255 + b) : 255 * c + 255 * b - c * b;
                  p = 510 * c - q;
                  o[0] = hsl_chan(p, q, a + 85);
                  o[1] = hsl_chan(p, q, a);
                  o[2] = hsl_chan(p, q, a - 85);
               end
            end
            default: begin
               k = (6 * a) / 255;
               u = (6 * a) % 510;
               if (k >= 6) k = 0;
               hue_dev = u - 255;
               if (hue_dev < 0) hue_dev = -hue_dev;
               cc = c * b * 255;
               x = c * b * (255 - hue_dev);
               m = 255 * c * (255 - b);
               case (k)
                  0: begin ch[0] = cc; ch[1] = x;  ch[2] = 0;  end
                  1: begin ch[0] = x;  ch[1] = cc; ch[2] = 0;  end
                  2: begin ch[0] = 0;  ch[1] = cc; ch[2] = x;  end
                  3: begin ch[0] = 0;  ch[1] = x;  ch[2] = cc; end
                  4: begin ch[0] = x;  ch[1] = 0;  ch[2] = cc; end
                  default: begin ch[0] = cc; ch[1] = 0; ch[2] = x; end
               endcase
               for (int i = 0; i < 3; i++) o[i] = to_byte(ch[i] + m, 65025);
            end
         endcase
         res.a = o[0][7:0]; res.b = o[1][7:0]; res.c = o[2][7:0];
         return res;
      endfunction

      function void note_request(pixel_type px);
         pending.insert(pending.size(), convert(px));
      endfunction

      task report(string what, int got, int want);
         errors++;
         $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, checked);
      endtask

      task check_result(pixel_type got);
         pixel_type want;
         if (pending.size() == 0) begin
            report("unexpected result", got.a, -1);
         end else begin
            want = pending.pop_front();
            if (got.a !== want.a) report("out_a", got.a, want.a);
            if (got.b !== want.b) report("out_b", got.b, want.b);
            if (got.c !== want.c) report("out_c", got.c, want.c);
         end
         checked++;
      endtask
   endclass

   logic     clock;
   logic     reset;
   logic     csr_valid;
   logic     csr_ready;
   logic [1:0] csr_data;
   logic     req_valid;
   logic     req_ready;
   chan_type req_chan_a, req_chan_b, req_chan_c;
   logic     rsp_valid;
   logic     rsp_ready;
   chan_type rsp_out_a, rsp_out_b, rsp_out_c;

   pixel_scoreboard color_sb;
   bit       quiet;      // no idling in the last part
   int       dog;
   int       sent;

   rgb_hsv_hsl_converter #(.FRAC_BITS(FRAC)) u_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_chan_a(req_chan_a), .req_chan_b(req_chan_b), .req_chan_c(req_chan_c),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_a(rsp_out_a), .rsp_out_b(rsp_out_b), .rsp_out_c(rsp_out_c)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: note requests, check results, feed the watchdog
   always @(posedge clock) begin
      pixel_type px;
      if (!reset) begin
         if (req_valid && req_ready) begin
            px.a = req_chan_a; px.b = req_chan_b; px.c = req_chan_c;
            color_sb.note_request(px);
         end
         if (rsp_valid && rsp_ready) begin
            px.a = rsp_out_a; px.b = rsp_out_b; px.c = rsp_out_c;
            color_sb.check_result(px);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            dog <= 0;
         else
            dog <= dog + 1;
         if (dog >= DOG_LIMIT) begin
            $display("watchdog expired, %0d results pending", color_sb.pending.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // result side stalls in bursts
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_ready <= 1'b1;
         n = $urandom_range(1, 40);
         repeat (n) @(negedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic write_mode(mode_type m);
      csr_valid <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      color_sb.mode = m;
   endtask

   // hold one pixel request until taken, with an optional idle burst first
   task automatic send_pixel(chan_type a, chan_type b, chan_type c);
      int n;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         n = $urandom_range(1, 17);
         repeat (n) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_chan_a <= a;
      req_chan_b <= b;
      req_chan_c <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (color_sb.pending.size() != 0) @(negedge clock);
      repeat (FRAC + 20) @(negedge clock);
   endtask

   task automatic directed_set();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd1);    // hue just below one turn
      send_pixel(8'd128, 8'd128, 8'd128); // grey
      send_pixel(8'd200, 8'd0, 8'd128);  // zero saturation in hsl input
      send_pixel(8'd255, 8'd200, 8'd100);
      send_pixel(8'd85, 8'd170, 8'd127);
      send_pixel(8'd170, 8'd255, 8'd128);
      send_pixel(8'd1, 8'd254, 8'd200);
   endtask

   initial begin
      mode_type seq[6];
      int       per;
      color_sb  = new();
      quiet     = 1'b0;
      dog       = 0;
      sent      = 0;
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_data  = '0;
      req_valid = 1'b0;
      req_chan_a = '0; req_chan_b = '0; req_chan_c = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed pixels under the reset mode, then each other mode
      directed_set();
      drain();
      seq = '{MODE_HSL_RGB, MODE_RGB_HSV, MODE_HSV_RGB, MODE_RGB_HSL,
              MODE_HSV_RGB, MODE_HSL_RGB};
      for (int i = 1; i < 4; i++) begin
         write_mode(seq[i - 1]);
         directed_set();
         drain();
      end

      // random pixels in phases, last phase with no idling
      per = N_RANDOM / 6;
      for (int ph = 0; ph < 6; ph++) begin
         write_mode(seq[ph]);
         if (ph == 5) quiet = 1'b1;
         for (int i = 0; i < per; i++)
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
         drain();
      end

      $display("covered %0d pixels, %0d results checked over all four modes",
               sent, color_sb.checked);
      if (color_sb.errors == 0 && color_sb.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/rhc_pkg.sv
hw/rtl/rhc_front.sv
hw/rtl/rhc_queue.sv
hw/rtl/rhc_divider.sv
hw/rtl/rgb_hsv_hsl_converter.sv
verif/tb_rgb_hsv_hsl_converter.sv
